// ===== src/egcd_pkg.sv =====
// Package: shared constants, types and state codes for the extended gcd block.
`default_nettype none
package egcd_pkg;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int ERR_WIDTH = 2;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_ZERO      = 2'd1,
      ERR_RANGE     = 2'd2,
      ERR_NOT_COPRIME = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MUL_M,
      ST_UPDATE,
      ST_FINISH,
      ST_OUTPUT
   } state_type;
endpackage
`default_nettype wire

// ===== src/egcd_if.sv =====
// Interface: valid/ready channel with a generic payload.
`default_nettype none
interface egcd_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/egcd_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module egcd_div #(
   parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DATA_WIDTH-1:0] dividend,
   input  wire logic [DATA_WIDTH-1:0] divisor,
   output logic                       done,
   output logic [DATA_WIDTH-1:0]      quotient,
   output logic [DATA_WIDTH-1:0]      remainder
);
   localparam int CW = $clog2(DATA_WIDTH + 1);

   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DATA_WIDTH:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DATA_WIDTH-1]} - {1'b0, dsr_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(DATA_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DATA_WIDTH]) begin
            rem_in = trial[DATA_WIDTH-1:0];
         end else begin
            rem_in = {rem_ff[DATA_WIDTH-2:0], quo_ff[DATA_WIDTH-1]};
         end
         quo_in = {quo_ff[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

// ===== src/egcd_core.sv =====
// Sequencer: Euclidean steps on one divider and one shared multiplier.
`default_nettype none
module egcd_core #(
   parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic                         in_func,
   input  wire logic signed [DATA_WIDTH-1:0] in_x,
   input  wire logic signed [DATA_WIDTH-1:0] in_y,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic [DATA_WIDTH-2:0]             out_gcd,
   output logic signed [DATA_WIDTH-1:0]      out_a,
   output logic signed [DATA_WIDTH-1:0]      out_b,
   output logic [DATA_WIDTH-2:0]             out_inv,
   output logic [egcd_pkg::ERR_WIDTH-1:0]    out_err
);
   localparam int W = DATA_WIDTH;

   egcd_pkg::state_type state_ff, state_in;

   // sm: working pair; turn_ff picks which side is divided next
   logic [W-1:0] m_ff, m_in, n_ff, n_in;
   logic [W-1:0] mm_ff, mm_in, mn_ff, mn_in, nm_ff, nm_in, nn_ff, nn_in;
   logic [W-1:0] q_ff, q_in, prod_ff, prod_in, y_ff, y_in;
   logic         turn_ff, turn_in, func_ff, func_in, second_ff, second_in;
   logic [1:0]   err_ff, err_in;
   logic [W-2:0] gcd_ff, gcd_in, inv_ff, inv_in;
   logic [W-1:0] a_ff, a_in, b_ff, b_in;

   logic         div_start, div_done;
   logic [W-1:0] div_quo, div_rem, div_num, div_den;
   logic [W-1:0] mul_op, mul_res;
   logic [W-1:0] ga, gb, gg, inv_val;

   egcd_div #(.DATA_WIDTH(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_num),
      .divisor   (div_den),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign div_num = turn_ff ? m_ff : n_ff;
   assign div_den = turn_ff ? n_ff : m_ff;
   // one shared multiplier, operand chosen by phase and turn
   assign mul_op  = second_ff ? (turn_ff ? nn_ff : mn_ff) : (turn_ff ? nm_ff : mm_ff);
   assign mul_res = W'(q_ff * mul_op);

   always_comb begin
      state_in  = state_ff;
      m_in = m_ff; n_in = n_ff;
      mm_in = mm_ff; mn_in = mn_ff; nm_in = nm_ff; nn_in = nn_ff;
      q_in = q_ff; prod_in = prod_ff; y_in = y_ff;
      turn_in = turn_ff; func_in = func_ff; second_in = second_ff;
      err_in = err_ff; gcd_in = gcd_ff; inv_in = inv_ff; a_in = a_ff; b_in = b_ff;
      div_start = 1'b0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      ga = turn_ff ? mm_ff : nm_ff;
      gb = turn_ff ? mn_ff : nn_ff;
      gg = turn_ff ? m_ff : n_ff;
      inv_val = ga[W-1] ? ga + y_ff : ga;
      unique case (state_ff)
         egcd_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               func_in = in_func;
               y_in    = in_y;
               m_in  = in_x[W-1] ? W'(-in_x) : in_x;
               n_in  = in_y[W-1] ? W'(-in_y) : in_y;
               mm_in = in_x[W-1] ? '1 : W'(1);
               nn_in = in_y[W-1] ? '1 : W'(1);
               mn_in = '0;
               nm_in = '0;
               turn_in = 1'b0;
               err_in  = egcd_pkg::ERR_NONE;
               if (in_func) begin
                  if (in_x <= 0 || in_x >= in_y) err_in = egcd_pkg::ERR_RANGE;
               end else if (in_x == 0 && in_y == 0) begin
                  err_in = egcd_pkg::ERR_ZERO;
               end
               state_in = egcd_pkg::ST_CHECK;
            end
         end
         egcd_pkg::ST_CHECK: begin
            // an error or a zero divisor ends the run
            if (err_ff != egcd_pkg::ERR_NONE) begin
               state_in = egcd_pkg::ST_FINISH;
            end else if ((turn_ff ? n_ff : m_ff) == '0) begin
               state_in = egcd_pkg::ST_FINISH;
            end else begin
               state_in = egcd_pkg::ST_DIV_START;
            end
         end
         egcd_pkg::ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = egcd_pkg::ST_DIV_WAIT;
         end
         egcd_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               q_in      = div_quo;
               second_in = 1'b0;
               if (turn_ff) m_in = div_rem;
               else         n_in = div_rem;
               state_in  = egcd_pkg::ST_MUL_M;
            end
         end
         egcd_pkg::ST_MUL_M: begin
            prod_in  = mul_res;
            state_in = egcd_pkg::ST_UPDATE;
         end
         egcd_pkg::ST_UPDATE: begin
            if (!turn_ff) begin
               if (!second_ff) nm_in = nm_ff - prod_ff;
               else            nn_in = nn_ff - prod_ff;
            end else begin
               if (!second_ff) mm_in = mm_ff - prod_ff;
               else            mn_in = mn_ff - prod_ff;
            end
            if (!second_ff) begin
               second_in = 1'b1;
               state_in  = egcd_pkg::ST_MUL_M;
            end else begin
               turn_in  = ~turn_ff;
               state_in = egcd_pkg::ST_CHECK;
            end
         end
         egcd_pkg::ST_FINISH: begin
            gcd_in = '0; a_in = '0; b_in = '0; inv_in = '0;
            if (err_ff == egcd_pkg::ERR_NONE) begin
               if (func_ff && gg != W'(1)) begin
                  err_in = egcd_pkg::ERR_NOT_COPRIME;
               end else begin
                  gcd_in = gg[W-2:0];
                  a_in   = ga;
                  b_in   = gb;
                  if (func_ff) inv_in = inv_val[W-2:0];
               end
            end
            state_in = egcd_pkg::ST_OUTPUT;
         end
         egcd_pkg::ST_OUTPUT: begin
            out_valid = 1'b1;
            if (out_ready) state_in = egcd_pkg::ST_IDLE;
         end
         default: state_in = egcd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= egcd_pkg::ST_IDLE;
      else       state_ff <= state_in;
      m_ff <= m_in; n_ff <= n_in;
      mm_ff <= mm_in; mn_ff <= mn_in; nm_ff <= nm_in; nn_ff <= nn_in;
      q_ff <= q_in; prod_ff <= prod_in; y_ff <= y_in;
      turn_ff <= turn_in; func_ff <= func_in; second_ff <= second_in;
      err_ff <= err_in; gcd_ff <= gcd_in; inv_ff <= inv_in; a_ff <= a_in; b_ff <= b_in;
   end

   assign out_gcd = gcd_ff;
   assign out_a   = a_ff;
   assign out_b   = b_ff;
   assign out_inv = inv_ff;
   assign out_err = err_ff;
endmodule
`default_nettype wire

// ===== src/extended_gcd_modular_inverse.sv =====
// Top level: extended gcd and modular inverse over valid/ready channels.
//
// Usage:
//   req channel: func (0 extended gcd, 1 inverse of first mod second) and
//   two signed operands. One word in gives exactly one word out on rsp.
//   rsp channel: gcd_value, coef_a, coef_b, inverse and error_code.
//   On error the numeric fields are zero and error_code says why.
// Sequence: each Euclidean half-step runs check, divider start and the
//   bit-serial divide, then a quotient multiply and coefficient update
//   for each of two coefficients, on one divider and one shared multiplier.
//   Range and zero errors go from the check state through finish
//   straight to the result word on rsp.
// Throughput: one word at a time; req_ready is high only while idle.
// Reset: synchronous, active high; returns to idle, drops any word in work.
// Stall: the result word is held on rsp until rsp_ready; no new req word
//   is taken meanwhile.
`default_nettype none
module extended_gcd_modular_inverse #(
   parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   egcd_if.sink     req,
   egcd_if.source   rsp
);
   egcd_core #(.DATA_WIDTH(DATA_WIDTH)) u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_func   (req.payload.func),
      .in_x      (req.payload.first_operand),
      .in_y      (req.payload.second_operand),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_gcd   (rsp.payload.gcd_value),
      .out_a     (rsp.payload.coef_a),
      .out_b     (rsp.payload.coef_b),
      .out_inv   (rsp.payload.inverse),
      .out_err   (rsp.payload.error_code)
   );
endmodule
`default_nettype wire

// ===== src/egcd_checker.sv =====
// Checker: port-level assertions for the top level, and its bind.
`default_nettype none
module egcd_checker #(
   parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEFAULT
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [egcd_pkg::ERR_WIDTH-1:0] rsp_err,
   input wire logic [DATA_WIDTH-2:0]          rsp_gcd
);
   a_not_both: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("req ready while rsp pending");
   a_no_ready_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("ready after accept");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("rsp dropped");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_err != egcd_pkg::ERR_NONE) |-> rsp_gcd == '0)
      else $error("gcd on error");
endmodule

bind extended_gcd_modular_inverse egcd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_err   (rsp.payload.error_code),
   .rsp_gcd   (rsp.payload.gcd_value)
);
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for the extended gcd / modular inverse block: directed and random words, scoreboard.
`timescale 1ns / 1ps
module tb;
   localparam int W = 32;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int RANDOM_PER_PHASE = 100;
   localparam logic FUNC_EGCD = 1'b0;
   localparam logic FUNC_INV  = 1'b1;
   localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

   // Field order follows the block's request and result descriptions, MSB first.
   typedef struct packed {
      logic                func;
      logic signed [W-1:0] first_operand;
      logic signed [W-1:0] second_operand;
   } req_word_type;

   typedef struct packed {
      logic [W-2:0]        gcd_value;
      logic signed [W-1:0] coef_a;
      logic signed [W-1:0] coef_b;
      logic [W-2:0]        inverse;
      egcd_pkg::err_type   error_code;
   } rsp_word_type;

   // Tracks expected result words in order and checks arrivals against them.
   class gcd_scoreboard;
      rsp_word_type pending[$];
      int           mismatches = 0;

      task report(string what);
         $display("MISMATCH @%0t: %s", $realtime, what);
         mismatches++;
      endtask

      // 64-bit wrapping arithmetic, truncated to the field widths (W-1 or W bits) at the end
      function rsp_word_type solve_word(req_word_type w);
         longint unsigned   x, y, m, n, mm, mn, nm, nn, q, g, a, b, inv;
         longint            sx, sy;
         rsp_word_type      r;
         egcd_pkg::err_type err;
         sx = w.first_operand;
         sy = w.second_operand;
         x = sx; y = sy;
         err = egcd_pkg::ERR_NONE;
         g = 0; a = 0; b = 0; inv = 0;
         if (w.func == FUNC_EGCD) begin
            if (x == 0 && y == 0) err = egcd_pkg::ERR_ZERO;
         end else if (!(sx > 0) || !(sx < sy)) begin
            err = egcd_pkg::ERR_RANGE;
         end
         if (err == egcd_pkg::ERR_NONE) begin
            m = x; n = y; mm = 1; mn = 0; nm = 0; nn = 1;
            if (sx < 0) begin m = 0 - m; mm = 0 - 64'd1; end
            if (sy < 0) begin n = 0 - n; nn = 0 - 64'd1; end
            // alternate remainders until one side empties
            forever begin
               if (m == 0) begin a = nm; b = nn; g = n; break; end
               q = n / m;
               nm -= q * mm; nn -= q * mn; n -= q * m;
               if (n == 0) begin a = mm; b = mn; g = m; break; end
               q = m / n;
               mm -= q * nm; mn -= q * nn; m -= q * n;
            end
            if (w.func == FUNC_INV) begin
               if (g != 1) err = egcd_pkg::ERR_NOT_COPRIME;
               else begin
                  inv = a;
                  if (inv[63]) inv += y;
               end
            end
         end
         if (err != egcd_pkg::ERR_NONE) begin g = 0; a = 0; b = 0; inv = 0; end
         r.gcd_value = g[W-2:0];
         r.coef_a = a[W-1:0];
         r.coef_b = b[W-1:0];
         r.inverse = inv[W-2:0];
         r.error_code = err;
         return r;
      endfunction

      function void note_request(req_word_type w);
         pending.push_back(solve_word(w));
      endfunction

      task check_result(rsp_word_type got);
         rsp_word_type exp_w;
         if (pending.size() == 0) begin
            report("result word with nothing pending");
            return;
         end
         exp_w = pending.pop_front();
         if (got.gcd_value !== exp_w.gcd_value)
            report($sformatf("gcd_value got %0d exp %0d", got.gcd_value, exp_w.gcd_value));
         if (got.coef_a !== exp_w.coef_a)
            report($sformatf("coef_a got %0d exp %0d", got.coef_a, exp_w.coef_a));
         if (got.coef_b !== exp_w.coef_b)
            report($sformatf("coef_b got %0d exp %0d", got.coef_b, exp_w.coef_b));
         if (got.inverse !== exp_w.inverse)
            report($sformatf("inverse got %0d exp %0d", got.inverse, exp_w.inverse));
         if (got.error_code !== exp_w.error_code)
            report($sformatf("error_code got %0d exp %0d", got.error_code,
                             exp_w.error_code));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles = 0;
   int   sender_idle = 0;   // percent of cycles the sender holds off
   int   recv_stall = 0;    // percent of cycles the receiver stalls

   egcd_if #(.payload_type(req_word_type)) req_if ();
   egcd_if #(.payload_type(rsp_word_type)) rsp_if ();

   extended_gcd_modular_inverse #(.DATA_WIDTH(W)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   gcd_scoreboard sb = new();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: limit covers the worst case for every word plus stalls, several times over.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver: check each accepted result word, then pick next cycle's ready.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_result(rsp_if.payload);
      rsp_if.ready <= !reset && ($urandom_range(99) >= recv_stall);
   end

   // Drive one word; valid stays up back to back unless the sender idles.
   task automatic send_word(req_word_type w);
      while ($urandom_range(99) < sender_idle) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= w;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(w);
   endtask

   task automatic send_pair(logic f, logic [W-1:0] x, logic [W-1:0] y);
      req_word_type w;
      w.func = f;
      w.first_operand = x;
      w.second_operand = y;
      send_word(w);
   endtask

   function automatic logic [W-1:0] pick_operand();
      case ($urandom_range(5))
         0: return $urandom_range(20);
         1: return -$urandom_range(20);
         2: return $urandom_range(65535) - 32768;
         3: return ($urandom_range(1)) ? MOST_NEG : MOST_POS;
         default: return $urandom;
      endcase
   endfunction

   // Half random egcd pairs; the rest mostly well-formed inverse requests (0 < p < q), some out of range.
   task automatic send_random();
      logic [W-1:0] q, p;
      if ($urandom_range(1)) begin
         send_pair(FUNC_EGCD, pick_operand(), pick_operand());
      end else if ($urandom_range(9) < 8) begin
         q = ($urandom_range(2)) ? $urandom_range(MOST_POS, 2) : $urandom_range(200, 2);
         p = $urandom_range(q - 1, 1);
         send_pair(FUNC_INV, p, q);
      end else begin
         send_pair(FUNC_INV, pick_operand(), pick_operand());
      end
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, both functions, each error path
      send_pair(FUNC_EGCD, 0, 0);                     // both zero
      send_pair(FUNC_EGCD, 0, 5);
      send_pair(FUNC_EGCD, 7, 0);
      send_pair(FUNC_EGCD, -12, 18);
      send_pair(FUNC_EGCD, 12, -18);
      send_pair(FUNC_EGCD, MOST_NEG, 0);              // gcd of 2^31 reads 0
      send_pair(FUNC_EGCD, MOST_NEG, MOST_NEG);
      send_pair(FUNC_EGCD, MOST_NEG, MOST_POS);
      send_pair(FUNC_EGCD, MOST_POS, MOST_POS);
      send_pair(FUNC_EGCD, -MOST_POS, 1);
      send_pair(FUNC_EGCD, 1836311903, 1134903170);   // Fibonacci: longest chain
      send_pair(FUNC_EGCD, -1, -1);
      send_pair(FUNC_INV, 3, 7);
      send_pair(FUNC_INV, 0, 0);                      // range check wins
      send_pair(FUNC_INV, 0, 7);
      send_pair(FUNC_INV, 7, 7);
      send_pair(FUNC_INV, -1, 7);
      send_pair(FUNC_INV, 5, -3);
      send_pair(FUNC_INV, 4, 8);                      // not coprime
      send_pair(FUNC_INV, 1, 2);
      send_pair(FUNC_INV, MOST_POS - 1, MOST_POS);
      send_pair(FUNC_INV, 1134903170, 1836311903);
      send_pair(FUNC_INV, MOST_NEG, MOST_POS);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin sender_idle = 0;  recv_stall = 0;  end
            1: begin sender_idle = 70; recv_stall = 0;  end
            2: begin sender_idle = 0;  recv_stall = 70; end
            default: begin sender_idle = 24; recv_stall = 24; end
         endcase
         for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random();
      end
      req_if.valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

// ===== files.f =====
src/egcd_pkg.sv
src/egcd_if.sv
src/egcd_div.sv
src/egcd_core.sv
src/extended_gcd_modular_inverse.sv
src/egcd_checker.sv
sim/tb.sv
